@@ hdl/bmpu_pkg.sv @@
// bmpu_pkg: shared types and constants of the BMP pixel row unpacker.
// Used by every module of the block; depends on nothing.

package bmpu_pkg;

    // Defaults of the top level parameters.
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int WIDTH_BITS_DEF    = 16;

    localparam int COLOR_W   = 24;
    localparam int PIX_CNT_W = 4;       // holds 0..8 pixels per byte
    localparam int IDX_W     = 8;       // palette index as carried on the input word
    localparam int CFG_IDX_W = 1;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
    localparam int ROW_BITS_ROUND = 31;  // rounds row bits up to a 32-bit word
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b1;

    // Input word function codes.
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_DATA_BYTE = 1'b1;

    typedef enum logic [1:0] {
        DEPTH_1BPP  = 2'd0,
        DEPTH_4BPP  = 2'd1,
        DEPTH_8BPP  = 2'd2,
        DEPTH_24BPP = 2'd3
    } t_depth;

    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   pal_index;
        logic [COLOR_W-1:0] pal_color;
        logic [7:0]         data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       mono;
        logic       row_last;
        logic       item_last;
    } t_out_word;

    // Pixel job handed from the row tracker to the expander.
    typedef struct packed {
        logic [7:0]           data_byte;
        logic [PIX_CNT_W-1:0] count;     // pixels still to issue
        t_depth               depth;
        logic                 mono;
        logic                 row_last;  // last pixel of the job closes the row
        logic [COLOR_W-1:0]   rgb;       // assembled 24bpp color
    } t_job;

endpackage

@@ hdl/bmpu_palette.sv @@
// bmpu_palette: 24-bit palette memory with per-entry valid bits and
// registered read, plus copies of entries 0 and 1. Depends on bmpu_pkg.

module bmpu_palette #(
    parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [$clog2(PALETTE_DEPTH)-1:0]   i_wr_addr,
    input  logic [bmpu_pkg::COLOR_W-1:0]       i_wr_color,
    input  logic                               i_rd_en,
    input  logic [$clog2(PALETTE_DEPTH)-1:0]   i_rd_addr,
    output logic [bmpu_pkg::COLOR_W-1:0]       o_rd_color,
    output logic [bmpu_pkg::COLOR_W-1:0]       o_entry0,
    output logic [bmpu_pkg::COLOR_W-1:0]       o_entry1
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [AW-1:0] ADDR_ENTRY0 = AW'(0);
    localparam logic [AW-1:0] ADDR_ENTRY1 = AW'(1);

    logic [bmpu_pkg::COLOR_W-1:0] r_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0]     r_vld;
    logic [bmpu_pkg::COLOR_W-1:0] r_rd_data;
    logic                         r_rd_hit;
    logic [bmpu_pkg::COLOR_W-1:0] r_entry0;
    logic [bmpu_pkg::COLOR_W-1:0] r_entry1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_color;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits make never-written entries read as black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
            r_entry0 <= bmpu_pkg::COLOR_BLACK;
            r_entry1 <= bmpu_pkg::COLOR_BLACK;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
                if (i_wr_addr == ADDR_ENTRY0) begin
                    r_entry0 <= i_wr_color;
                end
                if (i_wr_addr == ADDR_ENTRY1) begin
                    r_entry1 <= i_wr_color;
                end
            end
            if (i_rd_en) begin
                r_rd_hit <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_color = r_rd_hit ? r_rd_data : bmpu_pkg::COLOR_BLACK;
    assign o_entry0   = r_entry0;
    assign o_entry1   = r_entry1;

endmodule

@@ hdl/bmpu_row_ctrl.sv @@
// bmpu_row_ctrl: column, row byte and 24bpp gather state; turns each data
// byte into a pixel job. Depends on bmpu_pkg.

module bmpu_row_ctrl #(
    parameter int WIDTH_BITS = bmpu_pkg::WIDTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [7:0]                   i_data_byte,
    input  bmpu_pkg::t_depth             i_depth,
    input  logic [WIDTH_BITS-1:0]        i_image_width,
    input  logic [bmpu_pkg::COLOR_W-1:0] i_entry0,
    input  logic [bmpu_pkg::COLOR_W-1:0] i_entry1,
    output bmpu_pkg::t_job               o_job
);

    localparam int RBC_W  = WIDTH_BITS + 2;   // aligned row length in bytes
    localparam int PROD_W = WIDTH_BITS + 6;   // row length in bits, rounded up

    logic [WIDTH_BITS-1:0] r_col, n_col;
    logic [RBC_W-1:0]      r_rbc, n_rbc;
    logic [15:0]           r_partial, n_partial;
    logic [1:0]            r_phase, n_phase;

    logic [PROD_W-1:0]     w_ext;
    logic [PROD_W-1:0]     row_bits;
    logic [PROD_W-1:0]     row_bits_up;
    logic [RBC_W-1:0]      row_len;
    logic [WIDTH_BITS-1:0] room;
    logic                  col_open;
    logic [bmpu_pkg::PIX_CNT_W-1:0] count;
    logic [WIDTH_BITS-1:0] col_next;
    logic [RBC_W:0]        rbc_inc;
    logic                  row_done;
    logic [15:0]           p_partial;
    logic [1:0]            p_phase;
    logic [bmpu_pkg::COLOR_W-1:0] rgb;

    // Aligned row length: ((bpp * width + 31) / 32) * 4 bytes.
    always_comb begin
        w_ext = PROD_W'(i_image_width);
        unique case (i_depth)
            bmpu_pkg::DEPTH_1BPP:  row_bits = w_ext;
            bmpu_pkg::DEPTH_4BPP:  row_bits = w_ext << 2;
            bmpu_pkg::DEPTH_8BPP:  row_bits = w_ext << 3;
            bmpu_pkg::DEPTH_24BPP: row_bits = (w_ext << 4) + (w_ext << 3);
        endcase
        row_bits_up = row_bits + PROD_W'(bmpu_pkg::ROW_BITS_ROUND);
        row_len     = {row_bits_up[WIDTH_BITS+4:5], 2'b00};
    end

    always_comb begin
        room      = i_image_width - r_col;
        col_open  = (r_col < i_image_width);
        count     = '0;
        p_partial = r_partial;
        p_phase   = r_phase;
        rgb       = {i_data_byte, r_partial};
        if (col_open) begin
            unique case (i_depth)
                bmpu_pkg::DEPTH_1BPP: begin
                    count = (room >= WIDTH_BITS'(8)) ? 4'd8 : room[3:0];
                end
                bmpu_pkg::DEPTH_4BPP: begin
                    count = (room >= WIDTH_BITS'(2)) ? 4'd2 : room[3:0];
                end
                bmpu_pkg::DEPTH_8BPP: begin
                    count = 4'd1;
                end
                bmpu_pkg::DEPTH_24BPP: begin
                    // Bytes arrive blue, green, red; phase 2 is the red phase (as is phase 3).
                    priority case (r_phase)
                        2'd0: begin
                            p_partial = {8'h00, i_data_byte};
                            p_phase   = 2'd1;
                        end
                        2'd1: begin
                            p_partial = {i_data_byte, r_partial[7:0]};
                            p_phase   = 2'd2;
                        end
                        default: begin
                            count     = 4'd1;
                            p_partial = '0;
                            p_phase   = 2'd0;
                        end
                    endcase
                end
            endcase
        end
        col_next = r_col + WIDTH_BITS'(count);
        rbc_inc  = {1'b0, r_rbc} + (RBC_W+1)'(1);
        row_done = (rbc_inc >= {1'b0, row_len});
    end

    always_comb begin
        n_col     = r_col;
        n_rbc     = r_rbc;
        n_partial = r_partial;
        n_phase   = r_phase;
        if (i_take) begin
            if (row_done) begin
                n_col     = '0;
                n_rbc     = '0;
                n_partial = '0;
                n_phase   = 2'd0;
            end else begin
                n_col     = col_next;
                n_rbc     = rbc_inc[RBC_W-1:0];
                n_partial = p_partial;
                n_phase   = p_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_rbc     <= '0;
            r_partial <= '0;
            r_phase   <= 2'd0;
        end else begin
            r_col     <= n_col;
            r_rbc     <= n_rbc;
            r_partial <= n_partial;
            r_phase   <= n_phase;
        end
    end

    always_comb begin
        o_job.data_byte = i_data_byte;
        o_job.count     = count;
        o_job.depth     = i_depth;
        o_job.mono      = (i_depth == bmpu_pkg::DEPTH_1BPP)
                          && (i_entry0 == bmpu_pkg::COLOR_BLACK)
                          && (i_entry1 == bmpu_pkg::COLOR_WHITE);
        o_job.row_last  = (col_next == i_image_width);
        o_job.rgb       = rgb;
    end

endmodule

@@ hdl/bmpu_expander.sv @@
// bmpu_expander: holds a pixel job; unless stalled, issues one pixel per
// cycle into a palette read stage and presents it. Depends on bmpu_pkg.

module bmpu_expander #(
    parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  bmpu_pkg::t_job                     i_job,
    input  logic                               i_out_free,
    input  logic [bmpu_pkg::COLOR_W-1:0]       i_entry0,
    input  logic [bmpu_pkg::COLOR_W-1:0]       i_entry1,
    input  logic [bmpu_pkg::COLOR_W-1:0]       i_rd_color,
    output logic                               o_job_free,
    output logic                               o_rd_en,
    output logic [$clog2(PALETTE_DEPTH)-1:0]   o_rd_addr,
    output logic                               o_pix_valid,
    output bmpu_pkg::t_out_word                o_pix
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    typedef struct packed {
        logic from_mem;
        logic in_range;
        logic mono;
        logic row_last;
        logic item_last;
    } t_rd_ctl;

    bmpu_pkg::t_job               r_job;
    logic [2:0]                   r_pos;
    logic                         r_rd_valid;
    t_rd_ctl                      r_rd_ctl;
    logic [bmpu_pkg::COLOR_W-1:0] r_rd_direct;

    logic                          rd_adv;
    logic                          issue;
    logic                          last_pix;
    logic [bmpu_pkg::IDX_W-1:0]    idx;
    logic                          pix_bit;
    logic                          from_mem;
    logic                          in_range;
    logic [bmpu_pkg::COLOR_W-1:0]  direct;
    logic [bmpu_pkg::COLOR_W-1:0]  color;

    always_comb begin
        rd_adv   = !r_rd_valid || i_out_free;
        issue    = (r_job.count != '0) && rd_adv;
        last_pix = (r_job.count == bmpu_pkg::PIX_CNT_W'(1));
        pix_bit  = r_job.data_byte[3'd7 - r_pos];   // MSB first
        unique case (r_job.depth)
            bmpu_pkg::DEPTH_4BPP: begin
                idx = (r_pos == 3'd0) ? {4'h0, r_job.data_byte[7:4]}
                                      : {4'h0, r_job.data_byte[3:0] & bmpu_pkg::NIBBLE_MASK};
            end
            bmpu_pkg::DEPTH_8BPP: idx = r_job.data_byte;
            default:              idx = '0;
        endcase
        from_mem = (r_job.depth == bmpu_pkg::DEPTH_4BPP)
                   || (r_job.depth == bmpu_pkg::DEPTH_8BPP);
        in_range = ({1'b0, idx} < (bmpu_pkg::IDX_W+1)'(PALETTE_DEPTH));
        // 1bpp reads the copies of entries 0 and 1; 24bpp carries its color.
        direct   = (r_job.depth == bmpu_pkg::DEPTH_24BPP) ? r_job.rgb
                 : (pix_bit ? i_entry1 : i_entry0);
    end

    assign o_job_free = (r_job.count == '0) || (last_pix && issue);
    assign o_rd_en    = issue && from_mem && in_range;
    assign o_rd_addr  = idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.count <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_job <= i_job;
            end else if (issue) begin
                r_job.count <= r_job.count - bmpu_pkg::PIX_CNT_W'(1);
            end
            if (rd_adv) begin
                r_rd_valid <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos <= 3'd0;
        end else if (issue) begin
            r_pos <= r_pos + 3'd1;
        end
        if (issue) begin
            r_rd_ctl.from_mem  <= from_mem;
            r_rd_ctl.in_range  <= in_range;
            r_rd_ctl.mono      <= r_job.mono;
            r_rd_ctl.row_last  <= last_pix && r_job.row_last;
            r_rd_ctl.item_last <= last_pix;
            r_rd_direct        <= direct;
        end
    end

    always_comb begin
        if (!r_rd_ctl.from_mem) begin
            color = r_rd_direct;
        end else if (r_rd_ctl.in_range) begin
            color = i_rd_color;
        end else begin
            color = bmpu_pkg::COLOR_BLACK;
        end
        o_pix_valid     = r_rd_valid;
        o_pix.red       = color[23:16];
        o_pix.green     = color[15:8];
        o_pix.blue      = color[7:0];
        o_pix.mono      = r_rd_ctl.mono;
        o_pix.row_last  = r_rd_ctl.row_last;
        o_pix.item_last = r_rd_ctl.item_last;
    end

endmodule

@@ hdl/bmp_pixel_row_unpacker_unit.sv @@
// bmp_pixel_row_unpacker_unit: top level of the BMP pixel row unpacker.
// Depends on bmpu_pkg, bmpu_row_ctrl, bmpu_palette and bmpu_expander.
//
// Input words are palette writes or raw BMP pixel-data bytes; output words
// are RGB pixels, one per cycle unless the output stalls. A 1bpp data byte
// yields up to 8 pixels and holds the pixel expander until the last is
// issued; 4bpp yields up to 2, 8bpp one per byte, 24bpp one per 3 bytes;
// bytes that produce nothing (24bpp gather, row padding) leave it free. The
// next input word is taken in the cycle the expander issues its last pixel,
// so single-pixel traffic streams at one word per cycle unless the output
// stalls. A palette write is taken under the same rule, which keeps it off
// pixels of earlier bytes. Pixels pass the palette read register, then the
// output register. The palette is cleared at reset through per-entry valid
// bits, so no clearing pass is needed. Configuration writes go to depth_mode
// (index 0) and image_width (index 1) and must be made while the block is idle.

module bmp_pixel_row_unpacker_unit #(
    parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF,
    parameter int WIDTH_BITS    = bmpu_pkg::WIDTH_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input word channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bmpu_pkg::t_in_word                i_in_word,
    // output word channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bmpu_pkg::t_out_word               o_out_word,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bmpu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [WIDTH_BITS-1:0]             i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    // configuration registers
    bmpu_pkg::t_depth      r_depth;
    logic [WIDTH_BITS-1:0] r_width;

    // output register
    logic                  r_out_valid;
    bmpu_pkg::t_out_word   r_out_word;

    logic                         job_free;
    logic                         accept;
    logic                         take_byte;
    logic                         pal_wr;
    logic                         load;
    logic                         out_free;
    bmpu_pkg::t_job               job;
    logic [bmpu_pkg::COLOR_W-1:0] entry0;
    logic [bmpu_pkg::COLOR_W-1:0] entry1;
    logic [bmpu_pkg::COLOR_W-1:0] rd_color;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         pix_valid;
    bmpu_pkg::t_out_word          pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= bmpu_pkg::DEPTH_24BPP;
            r_width <= WIDTH_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bmpu_pkg::CFG_DEPTH_MODE:  r_depth <= bmpu_pkg::t_depth'(i_cfg_data[1:0]);
                bmpu_pkg::CFG_IMAGE_WIDTH: r_width <= i_cfg_data;
            endcase
        end
    end

    // Stall whenever the expander still has pixels to issue after this cycle.
    assign o_in_stall = !job_free;
    assign accept     = i_in_valid && job_free;
    assign take_byte  = accept && (i_in_word.func == bmpu_pkg::FUNC_DATA_BYTE);
    // writes beyond the palette depth are dropped
    assign pal_wr     = accept && (i_in_word.func == bmpu_pkg::FUNC_PAL_WRITE)
                        && ({1'b0, i_in_word.pal_index}
                            < (bmpu_pkg::IDX_W+1)'(PALETTE_DEPTH));
    // bytes with no pixels (gather, padding, full row) only move the counters
    assign load       = take_byte && (job.count != '0);

    bmpu_row_ctrl #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_row_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take_byte),
        .i_data_byte   (i_in_word.data_byte),
        .i_depth       (r_depth),
        .i_image_width (r_width),
        .i_entry0      (entry0),
        .i_entry1      (entry1),
        .o_job         (job)
    );

    bmpu_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (pal_wr),
        .i_wr_addr  (i_in_word.pal_index[AW-1:0]),
        .i_wr_color (i_in_word.pal_color),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_color (rd_color),
        .o_entry0   (entry0),
        .o_entry1   (entry1)
    );

    bmpu_expander #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_expander (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .i_out_free  (out_free),
        .i_entry0    (entry0),
        .i_entry1    (entry1),
        .i_rd_color  (rd_color),
        .o_job_free  (job_free),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_pix_valid (pix_valid),
        .o_pix       (pix)
    );

    // Output register: takes a new pixel when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && pix_valid) begin
            r_out_word <= pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
